// File: hdl/moog_ladder_filter_v1_unit_defines.svh
// Assertion macros for the ladder filter unit.
// Each use stands on a line of its own and carries no trailing semicolon.
`ifndef MOOG_LADDER_FILTER_V1_UNIT_DEFINES_SVH
`define MOOG_LADDER_FILTER_V1_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, clocked on aclk, muted while aresetn is low.
`define MLF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on aclk, muted while aresetn is low.
`define MLF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLF_ASSERT_IMP(lbl, ante, cons, msg)
`define MLF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/mlf_pkg.sv
`default_nettype none

package mlf_pkg;

    // Control register bank
    localparam int COEF_WIDTH      = 16;
    localparam int CFG_DATA_WIDTH  = COEF_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUTOFF    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESONANCE = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESPONSE  = 3'd3;

    localparam logic [COEF_WIDTH-1:0] CUTOFF_RESET    = 16'd32768;
    localparam logic [COEF_WIDTH-1:0] RESONANCE_RESET = 16'd0;

    typedef enum logic [1:0] {
        RESP_SILENT,
        RESP_LOWPASS,
        RESP_BANDPASS,
        RESP_HIGHPASS
    } response_t;

endpackage

`default_nettype wire

// File: hdl/moog_ladder_filter_v1_unit.sv
// Channel   | Dir | Handshake           | Payload
// ----------+-----+---------------------+-----------------------------------------
// s_        | in  | s_valid / s_ready   | s_sample_in  (signed, SAMPLE_WIDTH)
// m_        | out | m_valid / m_ready   | m_sample_out (signed, SAMPLE_WIDTH)
// cfg_      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// A filtered request runs from acceptance to the result register as 18 products through
// one shared signed multiplier, each in two half-width passes plus a commit step, then
// the done state forms the response. A bypassed request goes straight to the done state.
// s_ready is high only while the sequencer is idle, so a new request is accepted only
// after the previous one has left the done state; a finished result waits in the
// output register while the next request is already accepted and worked on, and a
// result still held there stalls the done state until it is taken.
// Reset (aresetn low, synchronous) clears the pole state, the sequencer and the registers
// to enable 0, cutoff 0.5, resonance 0, lowpass response. cfg_ready is always high.
`default_nettype none

`include "moog_ladder_filter_v1_unit_defines.svh"

module moog_ladder_filter_v1_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         s_sample_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         m_sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mlf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [mlf_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    // Number formats: state is signed with FRAC fraction bits (range -16 .. 16)
    localparam int W      = STATE_WIDTH;
    localparam int S      = SAMPLE_WIDTH;
    localparam int FRAC   = W - 5;
    localparam int SFRAC  = S - 1;
    localparam int XW     = W + 4;          // headroom for sums before saturation
    localparam int PW     = 2 * W + 1;      // full product width
    localparam int LO_W   = W / 2;          // low half of the multiplier operand
    localparam int HI_W   = W - LO_W;       // high half, signed
    localparam int YW     = W + S + 4;      // output before rescale and saturation
    localparam int CSHIFT = FRAC - mlf_pkg::COEF_WIDTH;

    // Constants rounded to nearest at FRAC bits
    localparam logic [63:0] K08_WIDE = ((64'd8 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] K56_WIDE = ((64'd56 << FRAC) + 64'd5) / 64'd10;
    localparam logic [63:0] K16_WIDE = ((64'd166667 << FRAC) + 64'd500000) / 64'd1000000;

    localparam logic signed [W-1:0] K08_Q = K08_WIDE[W-1:0];
    localparam logic signed [W-1:0] K56_Q = K56_WIDE[W-1:0];
    localparam logic signed [W-1:0] K16_Q = K16_WIDE[W-1:0];
    localparam logic signed [W-1:0] ONE_Q = {{(W-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_COMMIT
    } phase_t;

    // One entry for each product of the schedule
    typedef enum logic [4:0] {
        STEP_CK,        // c * k
        STEP_P,         // p = c + 0.8 * (c * k)
        STEP_KK,        // k * k
        STEP_INNER,     // 1 - k + 5.6 * k * k
        STEP_QSCALE,    // 1 + (k * inner) / 2
        STEP_Q,         // q = r * scale
        STEP_U,         // u = x - q * b4
        STEP_F1,
        STEP_P1,
        STEP_F2,
        STEP_P2,
        STEP_F3,
        STEP_P3,
        STEP_F4,
        STEP_P4,
        STEP_SQ,        // b4 * b4
        STEP_CUBE,      // b4 ^ 3
        STEP_CLIP       // b4 - b4 ^ 3 / 6
    } step_t;

    // Control
    state_t                     state_reg;
    phase_t                     phase_reg;
    step_t                      step_reg;
    logic                       m_valid_reg;
    logic                       bypass_reg;

    // Registers
    logic                       enable_reg;
    logic [mlf_pkg::COEF_WIDTH-1:0] cutoff_reg;
    logic [mlf_pkg::COEF_WIDTH-1:0] resonance_reg;
    mlf_pkg::response_t         response_reg;

    // Filter state
    logic signed [W-1:0]        prev_input_reg;
    logic signed [W-1:0]        pole_one_reg;
    logic signed [W-1:0]        pole_two_reg;
    logic signed [W-1:0]        pole_three_reg;
    logic signed [W-1:0]        pole_four_reg;

    // Datapath
    logic signed [S-1:0]        x_reg;
    logic signed [S-1:0]        m_sample_out_reg;
    logic signed [PW-1:0]       acc_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [W-1:0]        tmp_reg;
    logic signed [W-1:0]        old_reg;
    logic signed [W-1:0]        p_reg;
    logic signed [W-1:0]        q_reg;
    logic signed [W-1:0]        u_reg;

    logic signed [W-1:0]        c_val;
    logic signed [W-1:0]        r_val;
    logic signed [W-1:0]        k_val;
    logic signed [W-1:0]        f_val;
    logic signed [W:0]          op_a;
    logic signed [W-1:0]        op_b;
    logic signed [HI_W:0]       b_part;
    logic signed [W+HI_W+1:0]   part;
    logic signed [PW-1:0]       prod_shr;
    logic signed [W-1:0]        prod_q;
    logic signed [W-1:0]        stage_next;
    logic signed [XW-1:0]       xs_x;
    logic signed [XW-1:0]       diff_x;
    logic signed [XW-1:0]       band_x;
    logic signed [XW-1:0]       y_x;
    logic signed [YW-1:0]       y_scaled;
    logic signed [S-1:0]        y_sat;

    function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
        return XW'(v);
    endfunction

    // Clamp a widened sum to the state range
    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v[XW-1:W-1] == {(XW-W+1){v[XW-1]}}) begin
            r = v[W-1:0];
        end else if (v[XW-1]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign cfg_ready    = 1'b1;

    // Coefficient sources taken straight from the registers
    assign c_val = $signed({{(W-FRAC){1'b0}}, cutoff_reg, {CSHIFT{1'b0}}});
    assign r_val = $signed({{(W-FRAC){1'b0}}, resonance_reg, {CSHIFT{1'b0}}});
    assign k_val = ONE_Q - c_val;
    assign f_val = sat_w(ext(p_reg) + ext(p_reg) - ext(ONE_Q));

    // Operand selection for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            STEP_CK: begin
                op_a = (W+1)'(c_val);
                op_b = k_val;
            end
            STEP_P: begin
                op_a = (W+1)'(K08_Q);
                op_b = tmp_reg;
            end
            STEP_KK: begin
                op_a = (W+1)'(k_val);
                op_b = k_val;
            end
            STEP_INNER: begin
                op_a = (W+1)'(K56_Q);
                op_b = tmp_reg;
            end
            STEP_QSCALE: begin
                op_a = (W+1)'(k_val);
                op_b = tmp_reg;
            end
            STEP_Q: begin
                op_a = (W+1)'(r_val);
                op_b = tmp_reg;
            end
            STEP_U: begin
                op_a = (W+1)'(q_reg);
                op_b = pole_four_reg;
            end
            STEP_F1: begin
                op_a = (W+1)'(pole_one_reg);
                op_b = f_val;
            end
            STEP_P1: begin
                op_a = (W+1)'(u_reg) + (W+1)'(prev_input_reg);
                op_b = p_reg;
            end
            STEP_F2: begin
                op_a = (W+1)'(pole_two_reg);
                op_b = f_val;
            end
            STEP_P2: begin
                op_a = (W+1)'(pole_one_reg) + (W+1)'(old_reg);
                op_b = p_reg;
            end
            STEP_F3: begin
                op_a = (W+1)'(pole_three_reg);
                op_b = f_val;
            end
            STEP_P3: begin
                op_a = (W+1)'(pole_two_reg) + (W+1)'(old_reg);
                op_b = p_reg;
            end
            STEP_F4: begin
                op_a = (W+1)'(pole_four_reg);
                op_b = f_val;
            end
            STEP_P4: begin
                op_a = (W+1)'(pole_three_reg) + (W+1)'(old_reg);
                op_b = p_reg;
            end
            STEP_SQ: begin
                op_a = (W+1)'(pole_four_reg);
                op_b = pole_four_reg;
            end
            STEP_CUBE: begin
                op_a = (W+1)'(tmp_reg);
                op_b = pole_four_reg;
            end
            STEP_CLIP: begin
                op_a = (W+1)'(tmp_reg);
                op_b = K16_Q;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Shared multiplier: low half of op_b (unsigned) first, signed high half second
    always_comb begin
        if (phase_reg == PH_LO) begin
            b_part = $signed({{(HI_W+1-LO_W){1'b0}}, op_b[LO_W-1:0]});
        end else begin
            b_part = $signed({op_b[W-1], op_b[W-1:LO_W]});
        end
    end

    assign part = op_a * b_part;

    // Drop FRAC bits (floor), then clamp to the state range
    assign prod_shr = prod_reg >>> FRAC;

    always_comb begin
        if (prod_shr[PW-1:W-1] == {(PW-W+1){prod_shr[PW-1]}}) begin
            prod_q = prod_shr[W-1:0];
        end else if (prod_shr[PW-1]) begin
            prod_q = {1'b1, {(W-1){1'b0}}};
        end else begin
            prod_q = {1'b0, {(W-1){1'b1}}};
        end
    end

    // Pole update: (input * p) - (pole * f), the second product waits in tmp_reg
    assign stage_next = sat_w(ext(prod_q) - ext(tmp_reg));

    // Input sample brought to the state scale
    generate
        if (FRAC >= SFRAC) begin : g_in_up
            assign xs_x = XW'(x_reg) <<< (FRAC - SFRAC);
        end else begin : g_in_down
            assign xs_x = XW'(x_reg >>> (SFRAC - FRAC));
        end
    endgenerate

    // Response selection
    assign diff_x = ext(pole_three_reg) - ext(pole_four_reg);
    assign band_x = diff_x + diff_x + diff_x;

    always_comb begin
        case (response_reg)
            mlf_pkg::RESP_LOWPASS:  y_x = ext(pole_four_reg);
            mlf_pkg::RESP_BANDPASS: y_x = band_x;
            mlf_pkg::RESP_HIGHPASS: y_x = ext(u_reg) - band_x - ext(pole_four_reg);
            default:                y_x = '0;
        endcase
    end

    generate
        if (FRAC >= SFRAC) begin : g_out_down
            assign y_scaled = YW'(y_x) >>> (FRAC - SFRAC);
        end else begin : g_out_up
            assign y_scaled = YW'(y_x) <<< (SFRAC - FRAC);
        end
    endgenerate

    always_comb begin
        if (y_scaled[YW-1:S-1] == {(YW-S+1){y_scaled[YW-1]}}) begin
            y_sat = y_scaled[S-1:0];
        end else if (y_scaled[YW-1]) begin
            y_sat = {1'b1, {(S-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(S-1){1'b1}}};
        end
    end

    // Sequencer, registers, filter state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_LO;
            step_reg       <= STEP_CK;
            m_valid_reg    <= 1'b0;
            bypass_reg     <= 1'b0;
            enable_reg     <= 1'b0;
            cutoff_reg     <= mlf_pkg::CUTOFF_RESET;
            resonance_reg  <= mlf_pkg::RESONANCE_RESET;
            response_reg   <= mlf_pkg::RESP_LOWPASS;
            prev_input_reg <= '0;
            pole_one_reg   <= '0;
            pole_two_reg   <= '0;
            pole_three_reg <= '0;
            pole_four_reg  <= '0;
        end else begin
            // register writes; unknown indexes are dropped
            if (cfg_valid) begin
                case (cfg_index)
                    mlf_pkg::REG_ENABLE:    enable_reg    <= cfg_data[0];
                    mlf_pkg::REG_CUTOFF:    cutoff_reg    <= cfg_data;
                    mlf_pkg::REG_RESONANCE: resonance_reg <= cfg_data;
                    mlf_pkg::REG_RESPONSE:  response_reg  <= mlf_pkg::response_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end

            // drop a taken result, unless the done state reloads the register
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        bypass_reg <= !enable_reg;
                        step_reg   <= STEP_CK;
                        phase_reg  <= PH_LO;
                        state_reg  <= enable_reg ? ST_RUN : ST_DONE;
                    end
                end
                ST_RUN: begin
                    case (phase_reg)
                        PH_LO: phase_reg <= PH_HI;
                        PH_HI: phase_reg <= PH_COMMIT;
                        PH_COMMIT: begin
                            phase_reg <= PH_LO;
                            case (step_reg)
                                STEP_P1: begin
                                    pole_one_reg   <= stage_next;
                                    prev_input_reg <= u_reg;
                                end
                                STEP_P2:   pole_two_reg   <= stage_next;
                                STEP_P3:   pole_three_reg <= stage_next;
                                STEP_P4:   pole_four_reg  <= stage_next;
                                STEP_CLIP: pole_four_reg  <= sat_w(ext(pole_four_reg) - ext(prod_q));
                                default: ;
                            endcase
                            if (step_reg == STEP_CLIP) begin
                                state_reg <= ST_DONE;
                            end else begin
                                step_reg <= step_t'(step_reg + 5'd1);
                            end
                        end
                        default: phase_reg <= PH_LO;
                    endcase
                end
                ST_DONE: begin
                    // hold until the result register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_sample_out_reg <= bypass_reg ? x_reg : y_sat;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Multiplier accumulation and intermediate values
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == ST_RUN) begin
            case (phase_reg)
                PH_LO: acc_reg <= PW'(part);
                PH_HI: prod_reg <= acc_reg + (PW'(part) <<< LO_W);
                PH_COMMIT: begin
                    case (step_reg)
                        STEP_CK:     tmp_reg <= prod_q;
                        STEP_P:      p_reg   <= sat_w(ext(c_val) + ext(prod_q));
                        STEP_KK:     tmp_reg <= prod_q;
                        STEP_INNER:  tmp_reg <= sat_w(ext(ONE_Q) - ext(k_val) + ext(prod_q));
                        STEP_QSCALE: tmp_reg <= sat_w(ext(ONE_Q) + ext(prod_q >>> 1));
                        STEP_Q:      q_reg   <= prod_q;
                        STEP_U:      u_reg   <= sat_w(xs_x - ext(prod_q));
                        STEP_F1:     tmp_reg <= prod_q;
                        STEP_P1:     old_reg <= pole_one_reg;
                        STEP_F2:     tmp_reg <= prod_q;
                        STEP_P2:     old_reg <= pole_two_reg;
                        STEP_F3:     tmp_reg <= prod_q;
                        STEP_P3:     old_reg <= pole_three_reg;
                        STEP_F4:     tmp_reg <= prod_q;
                        STEP_SQ:     tmp_reg <= prod_q;
                        STEP_CUBE:   tmp_reg <= prod_q;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    `MLF_ASSERT_NXT(a_run_starts_clean, s_valid && s_ready && enable_reg, state_reg == ST_RUN && step_reg == STEP_CK && phase_reg == PH_LO, "filtered request did not start at the first product")
    `MLF_ASSERT_IMP(a_commit_after_hi, state_reg == ST_RUN && phase_reg == PH_COMMIT, $past(phase_reg) == PH_HI, "product committed before its high pass")
    `MLF_ASSERT_IMP(a_result_from_done, $rose(m_valid_reg), $past(state_reg) == ST_DONE, "result raised outside the done state")
    `MLF_ASSERT_NXT(a_bypass_exact, state_reg == ST_DONE && bypass_reg && (!m_valid_reg || m_ready), m_sample_out == $past(x_reg), "bypassed sample altered")

endmodule

`default_nettype wire
